@@ design/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants for the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  // sample and average width, Q11.4
  localparam int unsigned DATA_W = 16;

  // status of the serial divider as seen by the controller
  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_status_t;

endpackage

@@ design/swa_cell.sv @@
// ----------------------------------------------------------------------------
// swa_cell
// One stage of the sample shift line: holds one sample and hands it to the
// next stage each time a new item enters.
// ----------------------------------------------------------------------------
module swa_cell import swa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_i,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic signed [DATA_W-1:0] sample_o
);

  logic signed [DATA_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

@@ design/swa_div.sv @@
// ----------------------------------------------------------------------------
// swa_div
// Serial signed divider: restoring division of the magnitude, one quotient
// bit per cycle, sign applied at the output. Truncates toward zero.
// ----------------------------------------------------------------------------
module swa_div import swa_pkg::*; #(
  parameter int unsigned DVD_W = 21,
  parameter int unsigned DVS_W = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic        [DVS_W-1:0] divisor_i,
  output logic signed [DVD_W-1:0] quotient_o,
  output swa_div_status_t         status_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // bring down the next dividend bit and try the subtract
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && (cnt_q == CNT_W'(DVD_W - 1))) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      quo_q <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign quotient_o    = neg_q ? -signed'(quo_q) : signed'(quo_q);
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ design/sliding_window_average_top.sv @@
// ----------------------------------------------------------------------------
// sliding_window_average_top
// Moving average over the last WINDOW gyro rate samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one Q11.4 signed sample per item; m_axis returns one Q11.4
//   signed average per item, the mean of the samples held so far (at most
//   WINDOW of them), truncated toward zero.
//   Samples move down a row of WINDOW cells; the cell at the end drops out of
//   the running sum as the new sample enters. The divide by the fill count
//   runs in a bit-serial divider, one quotient bit per cycle over the
//   SUM_W = 17 + clog2(WINDOW) bits of the sum.
//   The serial divider keeps one item in flight at a time; the next sample is
//   not accepted until the current average moves into the output register.
//   The average sits in an output register, so the next sample is taken while
//   it waits. If the receiver stalls longer, the next average waits in the
//   divider and s_axis_tready stays low until it moves out.
//   Reset clears the cells, the sum and the fill count at once.
// ----------------------------------------------------------------------------
module sliding_window_average_top import swa_pkg::*; #(
  parameter int unsigned WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] average
);

  localparam int unsigned SUM_W = 17 + $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                    in_accept;
  logic signed [DATA_W-1:0] tap [WINDOW+1];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  quotient;
  swa_div_status_t          div_st;
  logic                     div_start;
  logic                     out_free;
  logic                     out_load;
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_data_q;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign tap[0]    = signed'(s_axis_tdata);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swa_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (in_accept),
      .sample_i (tap[i]),
      .sample_o (tap[i+1])
    );
  end

  // the oldest sample leaves the sum as the new one enters
  assign sum_d = sum_q
               + {{(SUM_W - DATA_W){tap[0][DATA_W-1]}}, tap[0]}
               - {{(SUM_W - DATA_W){tap[WINDOW][DATA_W-1]}}, tap[WINDOW]};
  assign cnt_d = (cnt_q == CNT_W'(WINDOW)) ? cnt_q : cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (in_accept) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign div_start = (state_q == S_LOAD);

  swa_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = ((state_q == S_DIV && div_st.done) || state_q == S_HOLD) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_LOAD;
      end
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (div_st.done) state_d = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the mean of 16-bit samples always fits 16 bits
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= quotient[DATA_W-1:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_st.busy)
    else $error("input ready while divider busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> div_start)
    else $error("accepted item did not start a divide");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result load lost");
`endif

endmodule
